// ===== rtl/core/voltage_event_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Voltage event detector assertion macros
// Shared concurrent assertion forms for the detector's checker.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_EVENT_DETECTOR_MACROS_SVH
`define VOLTAGE_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VED_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ved_pkg.sv =====
// ----------------------------------------------------------------------------
// Voltage event detector package
// Field widths, word layouts, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ved_pkg;

   localparam int LEVEL_W    = 24;
   localparam int HOLD_W     = 7;
   localparam int CSR_IDX_W  = 2;

   // Clear updates beyond the first before an event closes
   localparam logic [HOLD_W-1:0] HOLD_ITEMS = 7'd100;
   // Phases checked; capped at the three level fields of the word
   localparam int NUM_PHASES  = 3;
   localparam int USED_PHASES = (NUM_PHASES > 3) ? 3 : NUM_PHASES;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

   // Request word: level_a, level_b, level_c from bit 0 up
   localparam int REQ_DATA_W = 3 * LEVEL_W;

   // Response word layout
   localparam int RSP_IN_EVENT = 0;
   localparam int RSP_STARTED  = 1;
   localparam int RSP_CLOSED   = 2;
   localparam int RSP_KEPT     = 3;
   localparam int RSP_DUR_LSB  = 4;
   localparam int RSP_MIN_LSB  = RSP_DUR_LSB + LEVEL_W;
   localparam int RSP_MAX_LSB  = RSP_MIN_LSB + LEVEL_W;
   localparam int RSP_USED_W   = RSP_MAX_LSB + LEVEL_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THR  = 2'd0,
      CSR_HIGH_THR = 2'd1,
      CSR_MIN_DUR  = 2'd2,
      CSR_MAX_DUR  = 2'd3
   } csr_reg_type;

endpackage

// ===== rtl/core/voltage_event_detector.sv =====
// Path: a req word is captured in the input reg when accepted, then its result is
// registered in the result reg, which loads when empty or being drained.
// Throughput: one word per cycle with no bubbles while rsp_tready is high; event
// state updates as each word leaves the input reg, chaining consecutive words.
// Reset: synchronous, active high; clears event state, valids and CSRs
// (max_duration resets to all ones, the others to zero).
// ----------------------------------------------------------------------------
// Voltage event detector
// In-band event tracking on per-update RMS levels of up to three phases.
// ----------------------------------------------------------------------------
module voltage_event_detector
   import ved_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // CSR write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [LEVEL_W-1:0]    csr_wdata,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // level_a, level_b, level_c
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // in_event, event_started, event_closed, event_kept, duration,
   // min_level, max_level, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0] low_thr_ff, high_thr_ff, min_dur_ff, max_dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= '0;
         high_thr_ff <= '0;
         min_dur_ff  <= '0;
         max_dur_ff  <= LEVEL_MAX;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_idx))
            CSR_LOW_THR:  low_thr_ff  <= csr_wdata;
            CSR_HIGH_THR: high_thr_ff <= csr_wdata;
            CSR_MIN_DUR:  min_dur_ff  <= csr_wdata;
            CSR_MAX_DUR:  max_dur_ff  <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input reg -> state update -> result reg.
   // The result reg loads when empty or being drained; the input reg
   // loads when empty or moving its word on.
   // ---------------------------------------------------------------
   logic                  in_vld_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_free;
   logic                  step;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) in_vld_ff <= req_tvalid;
         if (out_free)   out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_data_ff <= req_tdata;
   end

   // ---------------------------------------------------------------
   // Event state
   // ---------------------------------------------------------------
   logic               open_ff,    open_in;
   logic               ext_vld_ff, ext_vld_in;
   logic [LEVEL_W-1:0] lowest_ff,  lowest_in;
   logic [LEVEL_W-1:0] highest_ff, highest_in;
   logic [LEVEL_W-1:0] elapsed_ff, elapsed_in;
   logic [HOLD_W-1:0]  hold_ff,    hold_in;
   logic [LEVEL_W-1:0] latched_ff, latched_in;
   logic               started, closed, kept;
   logic [LEVEL_W-1:0] out_min, out_max;
   logic [RSP_DATA_W-1:0] out_data_in;

   always_comb begin
      logic [LEVEL_W-1:0] lvl [3];
      logic               any;
      lvl[0] = in_data_ff[0*LEVEL_W +: LEVEL_W];
      lvl[1] = in_data_ff[1*LEVEL_W +: LEVEL_W];
      lvl[2] = in_data_ff[2*LEVEL_W +: LEVEL_W];

      open_in    = open_ff;
      ext_vld_in = ext_vld_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      hold_in    = hold_ff;
      latched_in = latched_ff;
      started    = 1'b0;
      closed     = 1'b0;
      kept       = 1'b0;
      any        = 1'b0;

      // Running duration, saturating
      elapsed_in = (open_ff && elapsed_ff != LEVEL_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;

      // Extremes over violating phases, in phase order
      for (int p = 0; p < USED_PHASES; p++) begin
         if (lvl[p] > low_thr_ff && lvl[p] < high_thr_ff) begin
            if (!ext_vld_in || lvl[p] < lowest_in)  lowest_in  = lvl[p];
            if (!ext_vld_in || lvl[p] > highest_in) highest_in = lvl[p];
            ext_vld_in = 1'b1;
            any        = 1'b1;
         end
      end

      if (any) begin
         if (!open_ff) begin
            open_in    = 1'b1;
            started    = 1'b1;
            elapsed_in = '0;
            latched_in = '0;
         end
         hold_in = '0;
      end else if (open_ff) begin
         // First clear update after a violation latches the duration
         if (hold_ff == '0) latched_in = elapsed_in;
         if (hold_ff < HOLD_ITEMS) begin
            hold_in = hold_ff + 1'b1;
         end else begin
            open_in = 1'b0;
            closed  = 1'b1;
            kept    = !(latched_in < min_dur_ff || latched_in > max_dur_ff);
         end
      end

      // Report the extremes before a close wipes them
      out_min = lowest_in;
      out_max = highest_in;
      if (closed) begin
         ext_vld_in = 1'b0;
         lowest_in  = '0;
         highest_in = '0;
         hold_in    = '0;
      end

      out_data_in                              = '0;
      out_data_in[RSP_IN_EVENT]                = open_in;
      out_data_in[RSP_STARTED]                 = started;
      out_data_in[RSP_CLOSED]                  = closed;
      out_data_in[RSP_KEPT]                    = kept;
      out_data_in[RSP_DUR_LSB +: LEVEL_W]      = latched_in;
      out_data_in[RSP_MIN_LSB +: LEVEL_W]      = out_min;
      out_data_in[RSP_MAX_LSB +: LEVEL_W]      = out_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         ext_vld_ff <= 1'b0;
         lowest_ff  <= '0;
         highest_ff <= '0;
         elapsed_ff <= '0;
         hold_ff    <= '0;
         latched_ff <= '0;
      end else if (step) begin
         open_ff    <= open_in;
         ext_vld_ff <= ext_vld_in;
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         elapsed_ff <= elapsed_in;
         hold_ff    <= hold_in;
         latched_ff <= latched_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (step) out_data_ff <= out_data_in;
   end

endmodule

// ===== rtl/core/ved_checker.sv =====
// ----------------------------------------------------------------------------
// Voltage event detector checker
// Port-level consistency checks on response words, bound to the top level.
// ----------------------------------------------------------------------------
`include "voltage_event_detector_macros.svh"

module ved_checker
   import ved_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               in_event, started, closed, kept;
   logic [LEVEL_W-1:0] min_level, max_level;

   assign in_event  = rsp_tdata[RSP_IN_EVENT];
   assign started   = rsp_tdata[RSP_STARTED];
   assign closed    = rsp_tdata[RSP_CLOSED];
   assign kept      = rsp_tdata[RSP_KEPT];
   assign min_level = rsp_tdata[RSP_MIN_LSB +: LEVEL_W];
   assign max_level = rsp_tdata[RSP_MAX_LSB +: LEVEL_W];

   // A word that opens an event leaves it open
   `VED_ASSERT_NOW(a_start_open, clock, reset, rsp_tvalid && started, in_event, "start without open event")
   // A closing word never shows the event open, nor a fresh start
   `VED_ASSERT_NOW(a_close_shut, clock, reset, rsp_tvalid && closed, !in_event && !started, "close inconsistent")
   // Keep verdict only comes with a close
   `VED_ASSERT_NOW(a_kept_close, clock, reset, rsp_tvalid && kept, closed, "kept without close")
   // Tracked extremes stay ordered
   `VED_ASSERT_NOW(a_ext_order, clock, reset, rsp_tvalid, min_level <= max_level, "min above max")

endmodule

bind voltage_event_detector ved_checker u_ved_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);
